[design/bpru_pkg.sv]
// Shared types, constants and helper functions of the bit-packed record unpacker.
package bpru_pkg;

   localparam int DEF_BARCODE_WIDTH = 32;
   localparam int DEF_COUNT_WIDTH   = 32;

   localparam logic [6:0] STATUS_KEEP = 7'd8;
   localparam logic [6:0] UMI_KEEP    = 7'd64;
   localparam logic [3:0] BYTE_BITS   = 4'd8;

   typedef enum logic [2:0] {
      CSR_STATUS_BITS     = 3'd0,
      CSR_CB_BITS         = 3'd1,
      CSR_UMI_BITS        = 3'd2,
      CSR_RECORD_LIMIT    = 3'd3,
      CSR_WHITELIST_COUNT = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      FIELD_STATUS  = 2'd0,
      FIELD_BARCODE = 2'd1,
      FIELD_UMI     = 2'd2
   } field_sel_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_RUN   = 2'd1,
      ST_FLUSH = 2'd2
   } ctrl_state_type;

   typedef enum logic {
      OP_DATA = 1'b0,
      OP_END  = 1'b1
   } op_code_type;

   typedef struct packed {
      logic       op;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] record_index;
      logic [7:0]  status_value;
      logic [31:0] barcode_index;
      logic [63:0] umi_packed;
      logic        barcode_valid;
      logic        umi_valid;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [3:0]  status_bits;
      logic [5:0]  cb_bits;
      logic [6:0]  umi_bits;
      logic [31:0] record_limit;
      logic [31:0] whitelist_count;
   } cfg_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic step;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic widths_zero;
      logic byte_done;
      logic step_emits;
      logic pend_valid;
      logic out_free;
   } sts_type;

   function automatic logic [63:0] low_mask64(input logic [6:0] w);
      logic [63:0] m;
      if (w >= 7'd64) begin
         m = '1;
      end else begin
         m = (64'd1 << w[5:0]) - 64'd1;
      end
      return m;
   endfunction

   function automatic logic [7:0] low_mask8(input logic [3:0] k);
      logic [7:0] m;
      if (k >= BYTE_BITS) begin
         m = '1;
      end else begin
         m = (8'd1 << k[2:0]) - 8'd1;
      end
      return m;
   endfunction

endpackage

[design/bpru_csr.sv]
// Configuration registers of the record unpacker.
module bpru_csr
   import bpru_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output cfg_type     cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_STATUS_BITS:     cfg_in.status_bits     = csr_wdata[3:0];
            CSR_CB_BITS:         cfg_in.cb_bits         = csr_wdata[5:0];
            CSR_UMI_BITS:        cfg_in.umi_bits        = csr_wdata[6:0];
            CSR_RECORD_LIMIT:    cfg_in.record_limit    = csr_wdata;
            CSR_WHITELIST_COUNT: cfg_in.whitelist_count = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.status_bits     <= 4'd1;
         cfg_ff.cb_bits         <= 6'd16;
         cfg_ff.umi_bits        <= 7'd24;
         cfg_ff.record_limit    <= '0;
         cfg_ff.whitelist_count <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[design/bpru_controller.sv]
// Sequencer that steps the unpacker datapath through one byte at a time.
module bpru_controller
   import bpru_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_op,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_op == OP_END) begin
                  cmd.clear = 1'b1;
               end else if (!sts.widths_zero) begin
                  cmd.load = 1'b1;
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (sts.byte_done) begin
               state_in = ST_FLUSH;
            end else if (!(sts.step_emits && sts.pend_valid && !sts.out_free)) begin
               cmd.step = 1'b1;
            end
         end
         ST_FLUSH: begin
            if (!sts.pend_valid) begin
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[design/bpru_datapath.sv]
// Field accumulator, record holding register and result register of the unpacker.
module bpru_datapath
   import bpru_pkg::*;
#(
   parameter int BARCODE_WIDTH = DEF_BARCODE_WIDTH,
   parameter int COUNT_WIDTH   = DEF_COUNT_WIDTH
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  cmd_type    cmd,
   input  logic [7:0] load_byte,
   output sts_type    sts,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data
);

   localparam int LW = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;
   localparam int BX = (BARCODE_WIDTH > 32) ? BARCODE_WIDTH : 32;
   localparam logic [6:0] BARCODE_KEEP = 7'(BARCODE_WIDTH);

   logic [63:0]              accum_ff, accum_in;
   logic [6:0]               done_ff, done_in;
   field_sel_type            sel_ff, sel_in;
   logic [7:0]               status_ff, status_in;
   logic [BARCODE_WIDTH-1:0] barcode_ff, barcode_in;
   logic [COUNT_WIDTH-1:0]   count_ff, count_in;
   logic                     post_ff, post_in;
   logic [7:0]               byte_ff, byte_in;
   logic [3:0]               rem_ff, rem_in;
   rsp_type                  pend_ff, pend_in;
   logic                     pend_valid_ff, pend_valid_in;
   rsp_type                  out_ff, out_in;
   logic                     out_valid_ff, out_valid_in;

   logic [6:0]  width_cur, keep_cur, lim, room;
   logic        field_full, limit_hit, byte_done, close_now, absorb_now, emit_now;
   logic [3:0]  take;
   logic [7:0]  chunk, done_sum;
   logic [63:0] deposit;
   logic [6:0]  done_abs;
   logic [LW-1:0] count_ext;
   logic [BX-1:0] barcode_ext;
   rsp_type     rec;
   logic        out_free;

   always_comb begin
      case (sel_ff)
         FIELD_STATUS: begin
            width_cur = 7'(cfg.status_bits);
            keep_cur  = STATUS_KEEP;
         end
         FIELD_BARCODE: begin
            width_cur = 7'(cfg.cb_bits);
            keep_cur  = BARCODE_KEEP;
         end
         FIELD_UMI: begin
            width_cur = cfg.umi_bits;
            keep_cur  = UMI_KEEP;
         end
         default: begin
            width_cur = '0;
            keep_cur  = '0;
         end
      endcase
   end

   assign lim        = (width_cur < keep_cur) ? width_cur : keep_cur;
   assign field_full = done_ff >= width_cur;
   assign room       = width_cur - done_ff;
   assign limit_hit  = LW'(count_ff) >= LW'(cfg.record_limit);
   assign byte_done  = !post_ff && ((rem_ff == 4'd0) || limit_hit);

   assign close_now  = post_ff ? field_full
                               : (!byte_done && (sel_ff != FIELD_UMI) && field_full);
   assign absorb_now = !post_ff && !byte_done && !((sel_ff != FIELD_UMI) && field_full);
   assign emit_now   = close_now && (sel_ff == FIELD_UMI);

   assign take     = field_full ? 4'd1 : ((7'(rem_ff) < room) ? rem_ff : room[3:0]);
   assign chunk    = byte_ff & low_mask8(take);
   assign deposit  = (done_ff < 7'd64) ? (64'(chunk) << done_ff[5:0]) : '0;
   assign done_sum = 8'(done_ff) + 8'(take);
   assign done_abs = (done_sum > 8'd127) ? 7'd127 : done_sum[6:0];

   assign count_ext   = LW'(count_ff);
   assign barcode_ext = BX'(barcode_ff);

   always_comb begin
      rec               = '0;
      rec.record_index  = count_ext[31:0];
      rec.status_value  = status_ff;
      rec.barcode_index = barcode_ext[31:0];
      rec.umi_packed    = accum_ff;
      rec.barcode_valid = (status_ff != 8'd0) && (barcode_ff != '0) &&
                          (barcode_ext <= BX'(cfg.whitelist_count));
      rec.umi_valid     = (status_ff != 8'd0) && (accum_ff != 64'd0);
      rec.last_of_run   = 1'b0;
   end

   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      accum_in      = accum_ff;
      done_in       = done_ff;
      sel_in        = sel_ff;
      status_in     = status_ff;
      barcode_in    = barcode_ff;
      count_in      = count_ff;
      post_in       = post_ff;
      byte_in       = byte_ff;
      rem_in        = rem_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff && rsp_stall;

      if (cmd.clear) begin
         accum_in      = '0;
         done_in       = '0;
         sel_in        = FIELD_STATUS;
         status_in     = '0;
         barcode_in    = '0;
         count_in      = '0;
         post_in       = 1'b0;
         pend_valid_in = 1'b0;
      end

      if (cmd.load) begin
         byte_in = load_byte;
         rem_in  = BYTE_BITS;
         post_in = 1'b0;
      end

      if (cmd.step) begin
         if (close_now) begin
            accum_in = '0;
            done_in  = '0;
            case (sel_ff)
               FIELD_STATUS: begin
                  status_in = accum_ff[7:0];
                  sel_in    = FIELD_BARCODE;
               end
               FIELD_BARCODE: begin
                  barcode_in = accum_ff[BARCODE_WIDTH-1:0];
                  sel_in     = FIELD_UMI;
               end
               FIELD_UMI: begin
                  sel_in        = FIELD_STATUS;
                  count_in      = count_ff + COUNT_WIDTH'(1);
                  post_in       = 1'b0;
                  pend_in       = rec;
                  pend_valid_in = 1'b1;
                  if (pend_valid_ff) begin
                     out_in       = pend_ff;
                     out_valid_in = 1'b1;
                  end
               end
               default: begin
                  sel_in = FIELD_STATUS;
               end
            endcase
         end else if (absorb_now) begin
            accum_in = accum_ff | (deposit & low_mask64(lim));
            done_in  = done_abs;
            byte_in  = byte_ff >> take;
            rem_in   = rem_ff - take;
            post_in  = 1'b1;
         end else if (post_ff) begin
            post_in = 1'b0;
         end
      end

      if (cmd.flush && pend_valid_ff) begin
         out_in             = pend_ff;
         out_in.last_of_run = 1'b1;
         out_valid_in       = 1'b1;
         pend_valid_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff      <= '0;
         done_ff       <= '0;
         sel_ff        <= FIELD_STATUS;
         status_ff     <= '0;
         barcode_ff    <= '0;
         count_ff      <= '0;
         post_ff       <= 1'b0;
         rem_ff        <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         accum_ff      <= accum_in;
         done_ff       <= done_in;
         sel_ff        <= sel_in;
         status_ff     <= status_in;
         barcode_ff    <= barcode_in;
         count_ff      <= count_in;
         post_ff       <= post_in;
         rem_ff        <= rem_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   assign sts.widths_zero = (cfg.status_bits == 4'd0) && (cfg.cb_bits == 6'd0) &&
                            (cfg.umi_bits == 7'd0);
   assign sts.byte_done   = byte_done;
   assign sts.step_emits  = emit_now;
   assign sts.pend_valid  = pend_valid_ff;
   assign sts.out_free    = out_free;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear, cmd.load, cmd.step, cmd.flush}))
      else $error("conflicting datapath commands");

   a_flush_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.flush && pend_valid_ff) |-> !(out_valid_ff && rsp_stall))
      else $error("flush into occupied result register");

   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && emit_now && pend_valid_ff) |-> !(out_valid_ff && rsp_stall))
      else $error("record pushed into occupied result register");

   a_count_advance: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && emit_now) |=> (count_ff == COUNT_WIDTH'($past(count_ff) + 1'b1)))
      else $error("record counter did not advance on emit");

endmodule

[design/bit_packed_record_unpacker_unit.sv]
// Bit-packed record unpacker: takes one stream byte per item and returns the records
// it completes. Bits are consumed LSB first and merged into the current field by a
// single shift-and-merge unit, one segment per cycle unless a stalled result side
// holds the block; each field close is a step of its own. A byte is accepted, then
// its segments are merged, each merge followed by the field closes it completes and,
// where those closes do not end in a record, by a step that ends the merge; an
// end-of-byte check and the flush of its last record, if any, finish the byte. The
// last record of each byte is held until the byte is finished so that it can be
// marked as last of its run. A stalled result side holds the block whenever a record
// has to move into the occupied result register: a second record of a byte, or the
// last record when its byte ends. End-of-stream items, and data bytes while all widths
// are zero, are taken in the idle state without starting a byte. End-of-stream clears
// the decode state and keeps the configuration.
module bit_packed_record_unpacker_unit
   import bpru_pkg::*;
#(
   parameter int BARCODE_WIDTH = DEF_BARCODE_WIDTH,
   parameter int COUNT_WIDTH   = DEF_COUNT_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   bpru_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bpru_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.op),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   bpru_datapath #(
      .BARCODE_WIDTH (BARCODE_WIDTH),
      .COUNT_WIDTH   (COUNT_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .load_byte (req_data.data_byte),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[test/testbench.sv]
// Self-checking testbench for the bit-packed record unpacker: directed plan, random phases.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import bpru_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int LONG_HOLD      = 300;
   localparam int ITEM_TARGET    = 430;
   localparam int CALM_FROM      = 380;
   localparam int MAX_PER_BYTE   = 8;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   bit_packed_record_unpacker_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // decoder configuration as last written
   logic [3:0]  w_status;
   logic [5:0]  w_barcode;
   logic [6:0]  w_umi;
   logic [31:0] rec_limit;
   logic [31:0] list_size;

   // decoder state
   logic [63:0]   acc_bits;
   int            acc_count;
   field_sel_type cur_field;
   logic [7:0]    kept_status;
   logic [31:0]   kept_barcode;
   logic [31:0]   rec_total;

   rsp_type byte_recs[$];
   rsp_type pending_recs[$];

   int  errors;
   int  items_sent;
   int  ends_sent;
   int  recs_checked;
   int  reg_writes;
   int  most_per_byte;
   bit  dirty;
   bit  calm;
   bit  send_idle;
   bit  take_idle;
   int  long_hold_req;
   int  quiet_cycles;

   typedef struct {
      bit          is_reg;
      logic [2:0]  reg_index;
      logic [31:0] reg_value;
      req_type     item;
      int          typed_n;
      rsp_type     typed_rsp;
   } plan_row_type;

   plan_row_type plan_q[$];

   function automatic void clear_decoder();
      acc_bits     = '0;
      acc_count    = 0;
      cur_field    = FIELD_STATUS;
      kept_status  = '0;
      kept_barcode = '0;
      rec_total    = '0;
   endfunction

   function automatic int field_width(field_sel_type f);
      if (f == FIELD_STATUS) begin
         return int'(w_status);
      end else if (f == FIELD_BARCODE) begin
         return int'(w_barcode);
      end
      return int'(w_umi);
   endfunction

   function automatic int field_keep(field_sel_type f);
      if (f == FIELD_STATUS) begin
         return int'(STATUS_KEEP);
      end else if (f == FIELD_BARCODE) begin
         return DEF_BARCODE_WIDTH;
      end
      return int'(UMI_KEEP);
   endfunction

   function automatic void apply_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
         CSR_STATUS_BITS:     w_status  = v[3:0];
         CSR_CB_BITS:         w_barcode = v[5:0];
         CSR_UMI_BITS:        w_umi     = v[6:0];
         CSR_RECORD_LIMIT:    rec_limit = v;
         CSR_WHITELIST_COUNT: list_size = v;
         default: ;
      endcase
   endfunction

   function automatic void close_field();
      rsp_type rec;
      bit      ok;
      if (cur_field == FIELD_STATUS) begin
         kept_status = acc_bits[7:0];
         cur_field   = FIELD_BARCODE;
      end else if (cur_field == FIELD_BARCODE) begin
         kept_barcode = acc_bits[31:0];
         cur_field    = FIELD_UMI;
      end else begin
         if (byte_recs.size() < MAX_PER_BYTE) begin
            ok                = kept_status != 8'd0;
            rec.record_index  = rec_total;
            rec.status_value  = kept_status;
            rec.barcode_index = kept_barcode;
            rec.umi_packed    = acc_bits;
            rec.barcode_valid = ok && kept_barcode >= 32'd1 && kept_barcode <= list_size;
            rec.umi_valid     = ok && acc_bits != 64'd0;
            rec.last_of_run   = 1'b0;
            byte_recs = {byte_recs, rec};
         end
         rec_total = rec_total + 32'd1;
         cur_field = FIELD_STATUS;
      end
      acc_bits  = '0;
      acc_count = 0;
   endfunction

   function automatic void unpack_item(req_type r);
      int      lim;
      bit      was_umi;
      rsp_type tail;
      byte_recs.delete();
      if (r.op == OP_END) begin
         clear_decoder();
         return;
      end
      if (w_status == 4'd0 && w_barcode == 6'd0 && w_umi == 7'd0) begin
         return;
      end
      for (int i = 0; i < 8; i++) begin
         if (rec_total >= rec_limit) begin
            break;
         end
         while (cur_field != FIELD_UMI && acc_count >= field_width(cur_field)) begin
            close_field();
         end
         lim = field_width(cur_field);
         if (field_keep(cur_field) < lim) begin
            lim = field_keep(cur_field);
         end
         if (acc_count < lim) begin
            acc_bits[acc_count] = r.data_byte[i];
         end
         if (acc_count < 127) begin
            acc_count++;
         end
         while (acc_count >= field_width(cur_field)) begin
            was_umi = cur_field == FIELD_UMI;
            close_field();
            if (was_umi) begin
               break;
            end
         end
      end
      if (byte_recs.size() > 0) begin
         tail = byte_recs[byte_recs.size() - 1];
         tail.last_of_run = 1'b1;
         byte_recs[byte_recs.size() - 1] = tail;
      end
   endfunction

   function automatic void plan_reg(csr_index_type idx, logic [31:0] v);
      plan_row_type row;
      row           = '{default: '0};
      row.is_reg    = 1'b1;
      row.reg_index = idx;
      row.reg_value = v;
      plan_q = {plan_q, row};
   endfunction

   function automatic void plan_typed(op_code_type op, logic [7:0] b, int n, rsp_type t);
      plan_row_type row;
      row                = '{default: '0};
      row.item.op        = op;
      row.item.data_byte = b;
      row.typed_n        = n;
      row.typed_rsp      = t;
      plan_q = {plan_q, row};
   endfunction

   function automatic void plan_item(op_code_type op, logic [7:0] b);
      plan_typed(op, b, -1, '0);
   endfunction

   task automatic write_reg(logic [2:0] idx, logic [31:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      apply_reg(idx, v);
      reg_writes++;
   endtask

   task automatic offer(req_type r, int typed_n, rsp_type typed_rsp);
      csr_valid <= 1'b0;
      if (send_idle && !calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      unpack_item(r);
      if (typed_n < 0) begin
         foreach (byte_recs[j]) begin
            pending_recs = {pending_recs, byte_recs[j]};
         end
      end else if (typed_n > 0) begin
         pending_recs = {pending_recs, typed_rsp};
      end
      if (byte_recs.size() > most_per_byte) begin
         most_per_byte = byte_recs.size();
      end
      if (r.op == OP_END) begin
         ends_sent++;
      end
      items_sent++;
      dirty = 1'b1;
   endtask

   // drain the result side, then let a byte with no record finish
   task automatic settle();
      if (dirty) begin
         req_valid <= 1'b0;
         while (pending_recs.size() != 0) begin
            @(posedge clock);
         end
         repeat (SETTLE_CYCLES) @(posedge clock);
         dirty = 1'b0;
      end
   endtask

   task automatic note_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin : result_side
      int hold_left;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req > 0) begin
            hold_left     = long_hold_req;
            long_hold_req = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (take_idle && !calm && $urandom_range(0, 5) == 0) begin
            hold_left = $urandom_range(0, 12);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : record_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_recs.size() == 0) begin
            errors++;
            $display("%0t ns: unexpected record, expected none, got %h", $time, rsp_data);
         end else begin
            want = pending_recs.pop_front();
            note_field("record_index", want.record_index, rsp_data.record_index);
            note_field("status_value", want.status_value, rsp_data.status_value);
            note_field("barcode_index", want.barcode_index, rsp_data.barcode_index);
            note_field("umi_packed", want.umi_packed, rsp_data.umi_packed);
            note_field("barcode_valid", want.barcode_valid, rsp_data.barcode_valid);
            note_field("umi_valid", want.umi_valid, rsp_data.umi_valid);
            note_field("last_of_run", want.last_of_run, rsp_data.last_of_run);
            recs_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns: no progress, %0d records outstanding", $time, pending_recs.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin : stimulus
      int          ph;
      int          n_items;
      int          pick;
      logic [3:0]  ws;
      logic [5:0]  wc;
      logic [6:0]  wu;
      logic [31:0] lim;
      logic [31:0] wl;
      req_type     r;
      rsp_type     none;

      none          = '0;
      errors        = 0;
      items_sent    = 0;
      ends_sent     = 0;
      recs_checked  = 0;
      reg_writes    = 0;
      most_per_byte = 0;
      dirty         = 1'b0;
      calm          = 1'b0;
      send_idle     = 1'b1;
      take_idle     = 1'b1;
      long_hold_req = 0;
      quiet_cycles  = 0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;

      w_status  = 4'd1;
      w_barcode = 6'd16;
      w_umi     = 7'd24;
      rec_limit = '0;
      list_size = '0;
      clear_decoder();

      // record limit is zero out of reset
      plan_typed(OP_DATA, 8'hFF, 0, none);
      plan_reg(CSR_RECORD_LIMIT, 32'hFFFF_FFFF);
      plan_reg(CSR_WHITELIST_COUNT, 32'hFFFF_FFFF);
      plan_reg(CSR_STATUS_BITS, 32'd8);
      plan_reg(CSR_CB_BITS, 32'd0);
      plan_reg(CSR_UMI_BITS, 32'd0);
      plan_typed(OP_DATA, 8'h5A, 1, rsp_type'{32'd0, 8'h5A, 32'd0, 64'd0, 1'b0, 1'b0, 1'b1});
      plan_typed(OP_DATA, 8'h00, 1, rsp_type'{32'd1, 8'h00, 32'd0, 64'd0, 1'b0, 1'b0, 1'b1});
      plan_typed(OP_DATA, 8'h81, 1, rsp_type'{32'd2, 8'h81, 32'd0, 64'd0, 1'b0, 1'b0, 1'b1});
      plan_reg(CSR_STATUS_BITS, 32'd1);
      plan_reg(CSR_CB_BITS, 32'd1);
      plan_reg(CSR_UMI_BITS, 32'd1);
      plan_item(OP_DATA, 8'hFF);
      plan_item(OP_DATA, 8'hA5);
      plan_item(OP_DATA, 8'h00);
      plan_reg(CSR_STATUS_BITS, 32'd0);
      plan_reg(CSR_CB_BITS, 32'd0);
      plan_reg(CSR_UMI_BITS, 32'd0);
      plan_typed(OP_DATA, 8'hFF, 0, none);
      plan_reg(CSR_UMI_BITS, 32'd1);
      plan_item(OP_DATA, 8'hFF);
      plan_item(OP_DATA, 8'h6C);
      plan_typed(OP_END, 8'hFF, 0, none);
      plan_reg(CSR_STATUS_BITS, 32'd15);
      plan_reg(CSR_CB_BITS, 32'd63);
      plan_reg(CSR_UMI_BITS, 32'd127);
      plan_item(OP_DATA, 8'hFF);
      plan_item(OP_DATA, 8'h00);
      plan_item(OP_DATA, 8'hFF);
      plan_item(OP_DATA, 8'h96);
      // shrink widths under a partly decoded record
      plan_reg(CSR_STATUS_BITS, 32'd8);
      plan_reg(CSR_CB_BITS, 32'd8);
      plan_reg(CSR_UMI_BITS, 32'd4);
      plan_item(OP_DATA, 8'h3C);
      plan_item(OP_DATA, 8'hFF);
      plan_item(OP_END, 8'h00);
      plan_reg(CSR_STATUS_BITS, 32'd2);
      plan_reg(CSR_CB_BITS, 32'd2);
      plan_reg(CSR_WHITELIST_COUNT, 32'd2);
      plan_reg(CSR_RECORD_LIMIT, 32'd3);
      plan_item(OP_DATA, 8'h09);
      plan_item(OP_DATA, 8'hF5);
      plan_item(OP_DATA, 8'h0D);
      plan_item(OP_DATA, 8'hFF);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (plan_q[k]) begin
         if (plan_q[k].is_reg) begin
            settle();
            write_reg(plan_q[k].reg_index, plan_q[k].reg_value);
         end else begin
            offer(plan_q[k].item, plan_q[k].typed_n, plan_q[k].typed_rsp);
         end
      end

      ph = 0;
      while (items_sent < ITEM_TARGET) begin
         calm      = items_sent >= CALM_FROM;
         send_idle = $urandom_range(0, 3) != 0;
         take_idle = $urandom_range(0, 3) != 0;
         settle();
         pick = (ph < 2) ? ph : ((ph == 5) ? 2 : $urandom_range(0, 9));
         case (pick)
            0: begin
               ws = 4'd15;
               wc = 6'd63;
               wu = 7'd127;
            end
            1: begin
               ws = 4'd8;
               wc = 6'd32;
               wu = 7'd64;
            end
            2: begin
               ws = 4'd0;
               wc = 6'd0;
               wu = 7'd0;
            end
            default: begin
               ws = 4'($urandom_range(0, 8));
               wc = 6'($urandom_range(0, 12));
               wu = 7'($urandom_range(0, 16));
            end
         endcase
         case ($urandom_range(0, 5))
            0: lim = '0;
            1: lim = $urandom_range(1, 30);
            2: lim = $urandom;
            default: lim = '1;
         endcase
         case ($urandom_range(0, 3))
            0: wl = '0;
            1: wl = '1;
            default: wl = $urandom_range(0, 1 << ((wc > 6'd10) ? 10 : int'(wc)));
         endcase
         if (ph == 2) begin
            ws = 4'd1;
            wc = 6'd2;
            wu = 7'd3;
            lim = '1;
            wl = 32'd2;
         end
         write_reg(CSR_STATUS_BITS, {28'($urandom), ws});
         write_reg(CSR_CB_BITS, {26'($urandom), wc});
         write_reg(CSR_UMI_BITS, {25'($urandom), wu});
         write_reg(CSR_RECORD_LIMIT, lim);
         write_reg(CSR_WHITELIST_COUNT, wl);
         if ($urandom_range(0, 3) == 0) begin
            write_reg(CSR_WHITELIST_COUNT + 3'($urandom_range(1, 3)), $urandom);
         end
         if (ph == 2) begin
            long_hold_req = LONG_HOLD;
         end
         n_items = (pick == 2) ? 6 : $urandom_range(20, 40);
         for (int i = 0; i < n_items; i++) begin
            if (ph == 4 && i == n_items / 2) begin
               settle();
            end
            r.op        = ($urandom_range(0, 15) == 0) ? OP_END : OP_DATA;
            r.data_byte = 8'($urandom);
            offer(r, -1, none);
         end
         if ($urandom_range(0, 9) < 7) begin
            r.op        = OP_END;
            r.data_byte = 8'($urandom);
            offer(r, -1, none);
         end
         ph++;
      end

      settle();
      if (pending_recs.size() != 0) begin
         errors++;
         $display("%0t ns: %0d records never arrived", $time, pending_recs.size());
      end
      $display("covered %0d stream items (%0d end-of-stream) over %0d setting phases",
               items_sent, ends_sent, ph);
      $display("checked %0d records, up to %0d from one byte, %0d register writes",
               recs_checked, most_per_byte, reg_writes);
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
